>>> hdl/ppo_pkg.sv
package ppo_pkg;

	localparam int FRAC_BITS_DEF = 8;

	localparam int COORD_W   = 24;
	localparam int SIZE_W    = 13;
	localparam int FOCAL_W   = 12;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;

	localparam logic [SIZE_W-1:0]  SCREEN_WIDTH_RST   = 13'd320;
	localparam logic [SIZE_W-1:0]  SCREEN_HEIGHT_RST  = 13'd256;
	localparam logic [FOCAL_W-1:0] FOCAL_DISTANCE_RST = 12'd160;

	localparam logic signed [COORD_W-1:0] SAT_MAX = 24'sh7FFFFF;
	localparam logic signed [COORD_W-1:0] SAT_MIN = -24'sh800000;

	// Bit positions of the clip outcode.
	localparam int CLIP_LEFT   = 0;
	localparam int CLIP_RIGHT  = 1;
	localparam int CLIP_TOP    = 2;
	localparam int CLIP_BOTTOM = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCREEN_WIDTH   = 2'd0,
		REG_SCREEN_HEIGHT  = 2'd1,
		REG_FOCAL_DISTANCE = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] vert_x;
		logic signed [COORD_W-1:0] vert_y;
		logic signed [COORD_W-1:0] vert_z;
		logic                      last_vertex;
	} vertex_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] screen_x;
		logic signed [COORD_W-1:0] screen_y;
		logic [3:0]                clip_code;
		logic                      zero_depth;
		logic                      last;
	} result_t;

	// Per-coordinate flags that ride along the divider.
	typedef struct packed {
		logic c_neg;
		logic c_zero;
		logic off_neg;
		logic ovf;
	} coord_side_t;

	typedef struct packed {
		coord_side_t x;
		coord_side_t y;
		logic        zero_depth;
		logic        last;
	} side_t;

endpackage

>>> hdl/perspective_project_outcode.sv
// Channel  | Valid         | Stall         | Payload
// vertex   | vertex_valid  | vertex_stall  | vertex (vertex_t)
// result   | result_valid  | result_stall  | result (result_t)
// config   | cfg_we        | none          | cfg_index, cfg_data
//
// One vertex is accepted per cycle while vertex_stall is low. The restoring
// divider retires one quotient bit per stage for x and y in parallel. Each
// stage advances when it is empty or the stage after it advances, so bubbles
// are squeezed out and a stalled result does not stop earlier stages from
// filling. Reset clears the valid bits and restores the default screen size
// and focal distance.
module perspective_project_outcode
	import ppo_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 vertex_valid,
	output logic                 vertex_stall,
	input  vertex_t              vertex,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int PW   = COORD_W + FOCAL_W;
	localparam int NW   = PW + FRAC_BITS + 2;
	localparam int CW   = FOCAL_W + FRAC_BITS;
	localparam int QW   = ((CW > COORD_W) ? CW : COORD_W) + 1;
	localparam int HW   = NW - QW;
	localparam int RW   = COORD_W + 1;
	localparam int SW   = QW + 2;
	localparam int HALF = (1 << FRAC_BITS) >> 1;

	logic [SIZE_W-1:0]  screen_width_q;
	logic [SIZE_W-1:0]  screen_height_q;
	logic [FOCAL_W-1:0] focal_distance_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q   <= SCREEN_WIDTH_RST;
			screen_height_q  <= SCREEN_HEIGHT_RST;
			focal_distance_q <= FOCAL_DISTANCE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:   screen_width_q   <= cfg_data;
				REG_SCREEN_HEIGHT:  screen_height_q  <= cfg_data;
				REG_FOCAL_DISTANCE: focal_distance_q <= cfg_data[FOCAL_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage enables: a stage loads when it is empty or its successor loads.
	logic v_s1, v_s2, v_s4, v_s5;
	logic en_s1, en_s2, en_s4, en_s5;
	logic v_s3  [0:QW];
	logic en_s3 [0:QW];

	assign en_s5 = !v_s5 || !result_stall;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3[QW] = !v_s3[QW] || en_s4;
	for (genvar k = 0; k < QW; k++) begin : g_en
		assign en_s3[k] = !v_s3[k] || en_s3[k+1];
	end
	assign en_s2 = !v_s2 || en_s3[0];
	assign en_s1 = !v_s1 || en_s2;
	assign vertex_stall = !en_s1;

	// Stage 1: magnitudes and signs.
	logic [COORD_W-1:0] cm_x_s1, cm_y_s1, zm_s1;
	side_t              side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= vertex_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && vertex_valid) begin
			cm_x_s1 <= vertex.vert_x[COORD_W-1] ? COORD_W'(-vertex.vert_x) : vertex.vert_x;
			cm_y_s1 <= vertex.vert_y[COORD_W-1] ? COORD_W'(-vertex.vert_y) : vertex.vert_y;
			zm_s1   <= vertex.vert_z[COORD_W-1] ? COORD_W'(-vertex.vert_z) : vertex.vert_z;
			side_s1.x.c_neg    <= vertex.vert_x[COORD_W-1];
			side_s1.x.c_zero   <= (vertex.vert_x == '0);
			side_s1.x.off_neg  <= (vertex.vert_x[COORD_W-1] == vertex.vert_z[COORD_W-1]);
			side_s1.x.ovf      <= 1'b0;
			side_s1.y.c_neg    <= vertex.vert_y[COORD_W-1];
			side_s1.y.c_zero   <= (vertex.vert_y == '0);
			side_s1.y.off_neg  <= (vertex.vert_y[COORD_W-1] == vertex.vert_z[COORD_W-1]);
			side_s1.y.ovf      <= 1'b0;
			side_s1.zero_depth <= (vertex.vert_z == '0);
			side_s1.last       <= vertex.last_vertex;
		end
	end

	// Stage 2: scale by the focal distance.
	logic [PW-1:0]      prod_x_s2, prod_y_s2;
	logic [COORD_W-1:0] zm_s2;
	side_t              side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			prod_x_s2 <= PW'(cm_x_s1) * PW'(focal_distance_q);
			prod_y_s2 <= PW'(cm_y_s1) * PW'(focal_distance_q);
			zm_s2     <= zm_s1;
			side_s2   <= side_s1;
		end
	end

	// Stage 3: rounded quotient (2*num + |z|) / (2*|z|), one bit per step.
	// Step 0 checks for a quotient too wide to matter; it then saturates.
	logic [RW-1:0] rem_x_s3 [0:QW];
	logic [RW-1:0] rem_y_s3 [0:QW];
	logic [QW-1:0] lo_x_s3  [0:QW];
	logic [QW-1:0] lo_y_s3  [0:QW];
	logic [QW-1:0] q_x_s3   [0:QW];
	logic [QW-1:0] q_y_s3   [0:QW];
	logic [RW-1:0] d_s3     [0:QW];
	side_t         side_s3  [0:QW];

	logic [NW-1:0] num_x, num_y;
	logic [RW-1:0] d_in;
	logic [RW-1:0] hi_x, hi_y;
	side_t         side_in;

	always_comb begin
		num_x = (NW'(prod_x_s2) << (FRAC_BITS + 1)) + NW'(zm_s2);
		num_y = (NW'(prod_y_s2) << (FRAC_BITS + 1)) + NW'(zm_s2);
		d_in  = {zm_s2, 1'b0};
		hi_x  = RW'(num_x[NW-1:QW]);
		hi_y  = RW'(num_y[NW-1:QW]);
		side_in       = side_s2;
		side_in.x.ovf = (hi_x >= d_in);
		side_in.y.ovf = (hi_y >= d_in);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3[0] <= 1'b0;
		end else if (en_s3[0]) begin
			v_s3[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3[0] && v_s2) begin
			rem_x_s3[0] <= hi_x;
			rem_y_s3[0] <= hi_y;
			lo_x_s3[0]  <= num_x[QW-1:0];
			lo_y_s3[0]  <= num_y[QW-1:0];
			q_x_s3[0]   <= '0;
			q_y_s3[0]   <= '0;
			d_s3[0]     <= d_in;
			side_s3[0]  <= side_in;
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_div
		logic [RW:0]   t_x, t_y;
		logic          ge_x, ge_y;
		logic [RW-1:0] nrem_x, nrem_y;

		always_comb begin
			t_x    = {rem_x_s3[k-1], lo_x_s3[k-1][QW-1]};
			t_y    = {rem_y_s3[k-1], lo_y_s3[k-1][QW-1]};
			ge_x   = (t_x >= {1'b0, d_s3[k-1]});
			ge_y   = (t_y >= {1'b0, d_s3[k-1]});
			nrem_x = ge_x ? RW'(t_x - {1'b0, d_s3[k-1]}) : RW'(t_x);
			nrem_y = ge_y ? RW'(t_y - {1'b0, d_s3[k-1]}) : RW'(t_y);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s3[k] <= 1'b0;
			end else if (en_s3[k]) begin
				v_s3[k] <= v_s3[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en_s3[k] && v_s3[k-1]) begin
				rem_x_s3[k] <= nrem_x;
				rem_y_s3[k] <= nrem_y;
				lo_x_s3[k]  <= lo_x_s3[k-1] << 1;
				lo_y_s3[k]  <= lo_y_s3[k-1] << 1;
				q_x_s3[k]   <= {q_x_s3[k-1][QW-2:0], ge_x};
				q_y_s3[k]   <= {q_y_s3[k-1][QW-2:0], ge_y};
				d_s3[k]     <= d_s3[k-1];
				side_s3[k]  <= side_s3[k-1];
			end
		end
	end

	// Stage 4: apply sign, add the screen center, saturate.
	function automatic logic signed [COORD_W-1:0] place(
		input logic [QW-1:0]     q,
		input coord_side_t       cs,
		input logic              zd,
		input logic [SIZE_W-1:0] size
	);
		logic [QW-1:0]        qe;
		logic signed [SW-1:0] off;
		logic signed [SW-1:0] centre;
		logic signed [SW-1:0] sum;
		logic signed [COORD_W-1:0] res;
		qe     = cs.ovf ? '1 : q;
		off    = cs.off_neg ? -$signed(SW'(qe)) : $signed(SW'(qe));
		centre = $signed(SW'(size[SIZE_W-1:1]) << FRAC_BITS);
		if (zd) begin
			off = '0;
		end
		sum = off + centre;
		if (zd && !cs.c_zero) begin
			res = cs.c_neg ? SAT_MAX : SAT_MIN;
		end else if (sum > SW'(SAT_MAX)) begin
			res = SAT_MAX;
		end else if (sum < SW'(SAT_MIN)) begin
			res = SAT_MIN;
		end else begin
			res = COORD_W'(sum);
		end
		return res;
	endfunction

	logic signed [COORD_W-1:0] sx_s4, sy_s4;
	side_t                     side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en_s4) begin
			v_s4 <= v_s3[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3[QW]) begin
			sx_s4   <= place(q_x_s3[QW], side_s3[QW].x, side_s3[QW].zero_depth,
				screen_width_q);
			sy_s4   <= place(q_y_s3[QW], side_s3[QW].y, side_s3[QW].zero_depth,
				screen_height_q);
			side_s4 <= side_s3[QW];
		end
	end

	// Stage 5: form the outcode from the position rounded to whole pixels. Returns {far, near}.
	function automatic logic [1:0] outcode(
		input logic signed [COORD_W-1:0] v,
		input logic [SIZE_W-1:0]         size
	);
		logic [RW-1:0] mag;
		logic [RW-1:0] pn;
		logic [RW-1:0] pp;
		logic [RW-1:0] px;
		logic          near;
		logic          far;
		mag  = RW'(-{v[COORD_W-1], v});
		pn   = (mag + RW'(HALF)) >> FRAC_BITS;
		pp   = ({1'b0, v} + RW'(HALF)) >> FRAC_BITS;
		near = v[COORD_W-1] && (pn != '0);
		px   = v[COORD_W-1] ? '0 : pp;
		far  = !near && (px >= RW'(size));
		return {far, near};
	endfunction

	result_t     res_s5;
	logic [1:0]  oc_x, oc_y;

	always_comb begin
		oc_x = outcode(sx_s4, screen_width_q);
		oc_y = outcode(sy_s4, screen_height_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en_s5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5 && v_s4) begin
			res_s5.screen_x               <= sx_s4;
			res_s5.screen_y               <= sy_s4;
			res_s5.clip_code[CLIP_LEFT]   <= oc_x[0];
			res_s5.clip_code[CLIP_RIGHT]  <= oc_x[1];
			res_s5.clip_code[CLIP_TOP]    <= oc_y[0];
			res_s5.clip_code[CLIP_BOTTOM] <= oc_y[1];
			res_s5.zero_depth             <= side_s4.zero_depth;
			res_s5.last                   <= side_s4.last;
		end
	end

	assign result_valid = v_s5;
	assign result       = res_s5;

	// The high remainder never exceeds the divisor width.
	localparam int HW_CHECK = (HW <= RW) ? 1 : 0;
	if (HW_CHECK == 0) begin : g_bad_width
		$error("remainder width too narrow");
	end

endmodule

>>> bench/perspective_project_outcode_test.sv
`timescale 1ns / 1ps

module perspective_project_outcode_test;
	import ppo_pkg::*;

	localparam int FRAC           = FRAC_BITS_DEF;
	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 1430;
	localparam int SETTING_COUNT  = 8;

	// Index with no register behind it; writes to it must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam logic signed [COORD_W-1:0] C_MAX = SAT_MAX;
	localparam logic signed [COORD_W-1:0] C_MIN = SAT_MIN;

	class projection_scoreboard;
		result_t          expected_q[$];
		logic [SIZE_W-1:0]  width;
		logic [SIZE_W-1:0]  height;
		logic [FOCAL_W-1:0] focal;
		int unsigned mismatches;
		int unsigned checked;
		int unsigned zero_depth_seen;
		int unsigned clipped_seen;
		int unsigned last_seen;

		function new();
			width  = SCREEN_WIDTH_RST;
			height = SCREEN_HEIGHT_RST;
			focal  = FOCAL_DISTANCE_RST;
			mismatches = 0;
			checked = 0;
			zero_depth_seen = 0;
			clipped_seen = 0;
			last_seen = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_SCREEN_WIDTH:   width  = data[SIZE_W-1:0];
				REG_SCREEN_HEIGHT:  height = data[SIZE_W-1:0];
				REG_FOCAL_DISTANCE: focal  = data[FOCAL_W-1:0];
				default: ;
			endcase
		endfunction

		function longint clamp24(longint v);
			if (v > longint'(SAT_MAX))
				return longint'(SAT_MAX);
			if (v < longint'(SAT_MIN))
				return longint'(SAT_MIN);
			return v;
		endfunction

		// Offset -(c * focal * 2^FRAC) / z, rounded to nearest with ties away from
		// zero, plus the integer half of the screen size.
		function longint project_axis(longint c, longint z, longint size);
			longint centre;
			longint cm;
			longint zm;
			longint num;
			longint q;
			longint off;
			bit     neg;
			centre = (size >>> 1) << FRAC;
			if (z == 0) begin
				if (c > 0)
					return longint'(SAT_MIN);
				if (c < 0)
					return longint'(SAT_MAX);
				return clamp24(centre);
			end
			cm = (c < 0) ? -c : c;
			zm = (z < 0) ? -z : z;
			num = (cm * longint'(focal)) << FRAC;
			q = (2 * num + zm) / (2 * zm);
			neg = !((c < 0) != (z < 0));
			off = neg ? -q : q;
			return clamp24(off + centre);
		endfunction

		function longint round_pixel(longint v);
			longint half;
			half = (longint'(1) << FRAC) >>> 1;
			if (v >= 0)
				return (v + half) >>> FRAC;
			return -((-v + half) >>> FRAC);
		endfunction

		function void note_vertex(vertex_t v);
			result_t e;
			longint  sx;
			longint  sy;
			longint  px;
			longint  py;
			longint  z;
			z  = longint'(v.vert_z);
			sx = project_axis(longint'(v.vert_x), z, longint'(width));
			sy = project_axis(longint'(v.vert_y), z, longint'(height));
			px = round_pixel(sx);
			py = round_pixel(sy);
			e = '0;
			e.screen_x = sx[COORD_W-1:0];
			e.screen_y = sy[COORD_W-1:0];
			if (px < 0)
				e.clip_code[CLIP_LEFT] = 1'b1;
			else if (px > longint'(width) - 1)
				e.clip_code[CLIP_RIGHT] = 1'b1;
			if (py < 0)
				e.clip_code[CLIP_TOP] = 1'b1;
			else if (py > longint'(height) - 1)
				e.clip_code[CLIP_BOTTOM] = 1'b1;
			e.zero_depth = (z == 0);
			e.last = v.last_vertex;
			expected_q.push_back(e);
		endfunction

		function void check_result(result_t r);
			result_t e;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: x=%0d y=%0d clip=%b zd=%b last=%b",
						r.screen_x, r.screen_y, r.clip_code, r.zero_depth, r.last);
				return;
			end
			e = expected_q.pop_front();
			checked++;
			if (e.zero_depth)
				zero_depth_seen++;
			if (e.clip_code != 4'd0)
				clipped_seen++;
			if (e.last)
				last_seen++;
			if (r.screen_x !== e.screen_x || r.screen_y !== e.screen_y ||
			    r.clip_code !== e.clip_code || r.zero_depth !== e.zero_depth ||
			    r.last !== e.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"Mismatch on result %0d: expected x=%0d y=%0d clip=%b zd=%b ",
						"last=%b, got x=%0d y=%0d clip=%b zd=%b last=%b"}, checked,
						e.screen_x, e.screen_y, e.clip_code, e.zero_depth, e.last,
						r.screen_x, r.screen_y, r.clip_code, r.zero_depth, r.last);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 vertex_valid;
	logic                 vertex_stall;
	vertex_t              vertex;
	logic                 result_valid;
	logic                 result_stall;
	result_t              result;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	projection_scoreboard sb;
	bit steady;
	int idle_cycles;

	perspective_project_outcode u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.vertex_valid (vertex_valid),
		.vertex_stall (vertex_stall),
		.vertex       (vertex),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic vertex_t make_vertex(longint x, longint y, longint z, bit last);
		vertex_t v;
		v.vert_x = x[COORD_W-1:0];
		v.vert_y = y[COORD_W-1:0];
		v.vert_z = z[COORD_W-1:0];
		v.last_vertex = last;
		return v;
	endfunction

	function automatic longint pick_extreme();
		case ($urandom_range(0, 4))
			0: return longint'(C_MIN);
			1: return longint'(C_MAX);
			2: return 0;
			3: return 1;
			default: return -1;
		endcase
	endfunction

	// Coordinate scattered around the view frustum for a depth of magnitude zmag.
	function automatic longint near_frustum(longint zmag);
		longint lim;
		lim = (zmag << 2) >>> $urandom_range(0, 8);
		if (lim > longint'(C_MAX))
			lim = longint'(C_MAX);
		return longint'($urandom_range(0, int'(2 * lim))) - lim;
	endfunction

	function automatic vertex_t random_vertex();
		vertex_t v;
		int      kind;
		longint  zmag;
		longint  z;
		bit      last;
		kind = $urandom_range(0, 99);
		last = ($urandom_range(0, 7) == 0);
		if (kind < 12) begin
			v = vertex_t'({$urandom(), $urandom(), $urandom()});
			v.last_vertex = last;
			return v;
		end
		if (kind < 17) begin
			v = make_vertex(0, 0, 0, last);
			v.vert_x = ($urandom_range(0, 2) == 0) ? '0 : COORD_W'($urandom());
			v.vert_y = ($urandom_range(0, 2) == 0) ? '0 : COORD_W'($urandom());
			return v;
		end
		if (kind < 23)
			return make_vertex(pick_extreme(), pick_extreme(), pick_extreme(), last);
		zmag = longint'($urandom_range(1, 1 << 22)) >>> $urandom_range(0, 12);
		if (zmag == 0)
			zmag = 1;
		z = ($urandom_range(0, 4) == 0) ? zmag : -zmag;
		return make_vertex(near_frustum(zmag), near_frustum(zmag), z, last);
	endfunction

	task automatic send_vertex(vertex_t v);
		int gap;
		vertex <= v;
		vertex_valid <= 1'b1;
		do
			@(posedge clk);
		while (vertex_stall);
		gap = gap_len();
		if (gap > 0) begin
			vertex_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// The extra edge lets the monitor note a vertex taken at the current edge.
	task automatic wait_for_results();
		vertex_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_we high; the caller lowers it after its last write.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic apply_setting(int w, int h, int f, bit touch_unused);
		write_reg(REG_SCREEN_WIDTH, CFG_W'(w));
		write_reg(REG_SCREEN_HEIGHT, CFG_W'(h));
		write_reg(REG_FOCAL_DISTANCE, CFG_W'(f));
		if (touch_unused)
			write_reg(REG_UNUSED, CFG_W'($urandom()));
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (vertex_valid && !vertex_stall)
				sb.note_vertex(vertex);
			if (result_valid && !result_stall)
				sb.check_result(result);
		end
	end

	always @(posedge clk) begin
		if ((vertex_valid && !vertex_stall) || (result_valid && !result_stall) || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
				idle_cycles, sb.pending());
			$display("TEST FAILED");
			$finish;
		end
	end

	// Receiver back-pressure: stall runs of random length between short open windows.
	initial begin
		int n;
		result_stall = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			n = gap_len();
			if (n > 0) begin
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			result_stall <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	initial begin
		vertex_t directed[$];
		int set_w[SETTING_COUNT];
		int set_h[SETTING_COUNT];
		int set_f[SETTING_COUNT];
		int per_phase;
		int sent;
		sb = new();
		steady = 1'b0;
		idle_cycles = 0;
		arst_n = 1'b0;
		vertex_valid = 1'b0;
		vertex = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sent = 0;

		set_w = '{1, 4096, 8191, 0, 640, 0, 0, 0};
		set_h = '{1, 4096, 8191, 0, 480, 0, 0, 0};
		set_f = '{1, 4095, 8191, 0, 320, 0, 0, 0};
		for (int i = 5; i < SETTING_COUNT; i++) begin
			set_w[i] = $urandom_range(1, 4096);
			set_h[i] = $urandom_range(1, 4096);
			set_f[i] = $urandom_range(1, 4095);
		end

		// Centre, exact screen edges, full-range coordinates and depths.
		directed.push_back(make_vertex(0, 0, -256, 0));
		directed.push_back(make_vertex(-256, -256, -256, 0));
		directed.push_back(make_vertex(256, 256, -256, 0));
		directed.push_back(make_vertex(256, 256, 256, 0));
		directed.push_back(make_vertex(C_MIN, C_MIN, 1, 0));
		directed.push_back(make_vertex(C_MAX, C_MAX, 1, 0));
		directed.push_back(make_vertex(C_MIN, C_MAX, -1, 0));
		directed.push_back(make_vertex(C_MAX, C_MIN, C_MIN, 0));
		directed.push_back(make_vertex(C_MAX, C_MAX, C_MAX, 0));
		directed.push_back(make_vertex(C_MIN, C_MIN, C_MIN, 1));
		directed.push_back(make_vertex(1, -1, -1, 0));
		directed.push_back(make_vertex(0, 0, C_MAX, 0));
		directed.push_back(make_vertex(0, 0, C_MIN, 1));
		// Zero depth with positive, negative and zero coordinates.
		directed.push_back(make_vertex(256, -256, 0, 0));
		directed.push_back(make_vertex(-1, 1, 0, 0));
		directed.push_back(make_vertex(0, 0, 0, 1));
		directed.push_back(make_vertex(C_MAX, C_MIN, 0, 0));
		// At this depth the offset equals the coordinate, so these land on the
		// half-pixel ties just outside and just inside each clip boundary.
		directed.push_back(make_vertex(-41088, -32896, -40960, 0));
		directed.push_back(make_vertex(-41087, -32895, -40960, 0));
		directed.push_back(make_vertex(40832, 32640, -40960, 0));
		directed.push_back(make_vertex(40831, 32639, -40960, 1));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			send_vertex(directed[i]);
			sent++;
		end

		per_phase = RANDOM_ITEMS / SETTING_COUNT;
		for (int p = 0; p < SETTING_COUNT; p++) begin
			wait_for_results();
			apply_setting(set_w[p], set_h[p], set_f[p], p == 4);
			steady = (p == 1 || p == 5);
			for (int i = 0; i < per_phase; i++) begin
				send_vertex(random_vertex());
				sent++;
			end
		end
		steady = 1'b0;
		wait_for_results();

		$display("Sent %0d vertices over %0d screen and focal settings plus reset values.",
			sent, SETTING_COUNT);
		$display("Checked %0d results: %0d at zero depth, %0d clipped, %0d marked last.",
			sb.checked, sb.zero_depth_seen, sb.clipped_seen, sb.last_seen);
		if (sb.mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

>>> sim.f
hdl/ppo_pkg.sv
hdl/perspective_project_outcode.sv
bench/perspective_project_outcode_test.sv
